/* rtl/rle_argb_image_blitter_top_defines.svh */
// assertion macros for the rle argb image blitter
// used by rle_argb_image_blitter_top only; empty when SYNTHESIS is defined
`ifndef RLE_ARGB_IMAGE_BLITTER_TOP_DEFINES_SVH
`define RLE_ARGB_IMAGE_BLITTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define RAB_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rab assertion failed");
// checked during reset as well
`define RAB_ASSERT_RST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("rab reset assertion failed");
`else
`define RAB_ASSERT(name, clk, rst, prop)
`define RAB_ASSERT_RST(name, clk, prop)
`endif

`endif

/* rtl/rab_pkg.sv */
// shared types, codes and constants of the rle argb image blitter
// no dependencies; imported by every module of the block
package rab_pkg;

  // one input item
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] data_word;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic        pixel_valid;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [23:0] pixel_color;
    logic [7:0]  pixel_alpha;
    logic        want_word;
    logic        image_done;
    logic [1:0]  status;
  } pix_t;

  // configuration registers
  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        raw_format;
    logic        tint_enable;
    logic [23:0] tint_color;
  } cfg_t;

  // classified item held in the queue between front and back
  typedef struct packed {
    logic [1:0]  kind;
    logic        hdr_block;
    logic [15:0] hdr_len;
    logic [31:0] word;
  } qitem_t;

  // action codes
  localparam logic [1:0] ACT_WORD  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  // decode phases
  localparam logic [1:0] PH_HDR     = 2'd0;
  localparam logic [1:0] PH_BLOCK   = 2'd1;
  localparam logic [1:0] PH_RUNWORD = 2'd2;
  localparam logic [1:0] PH_RUN     = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_WORD = 2'd1;
  localparam logic [1:0] STAT_BAD_TICK = 2'd2;

  // register indexes
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_RAW_FORMAT   = 3'd4;
  localparam logic [2:0] REG_TINT_ENABLE  = 3'd5;
  localparam logic [2:0] REG_TINT_COLOR   = 3'd6;

  // header decoding
  localparam logic [31:0] HDR_BLOCK_MASK = 32'hFFFF_FF00;
  localparam logic [8:0]  BLOCK_BASE     = 9'h100;

  // cursor skip divider: 17-bit dividend, one quotient bit a cycle
  localparam int unsigned DIV_W     = 17;
  localparam logic [4:0]  DIV_STEPS = 5'd17;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [15:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [15:0]      remainder;
  } div_rsp_t;

endpackage

/* rtl/rle_argb_image_blitter_top.sv */
// rle argb image blitter top: apb registers, item queue, decoder back end
// result: an item that needs no skip loads the result register as it is popped from the queue;
// a zero-length or transparent run loads it from FS_FIN, after FS_SKIP and, when the cursor wraps,
// FS_DIV and the 17-step skip divider; one item per cycle while the result register is free
// reset: synchronous, clears queue, decode state, cursor, result and registers
// depends on rab_pkg, rab_front, rab_div, rab_back and the defines header
`include "rle_argb_image_blitter_top_defines.svh"

module rle_argb_image_blitter_top
  import rab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_t                  cmd,
  output logic                  pix_valid,
  input  logic                  pix_ready,
  output pix_t                  pix,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t       cfg;
  logic [2:0] reg_idx;
  logic       q_valid;
  logic       q_pop;
  qitem_t     q_item;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_ORIGIN_X:     cfg.origin_x     <= pwdata[15:0];
        REG_ORIGIN_Y:     cfg.origin_y     <= pwdata[15:0];
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[15:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[15:0];
        REG_RAW_FORMAT:   cfg.raw_format   <= pwdata[0];
        REG_TINT_ENABLE:  cfg.tint_enable  <= pwdata[0];
        REG_TINT_COLOR:   cfg.tint_color   <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X:     prdata = {16'd0, cfg.origin_x};
      REG_ORIGIN_Y:     prdata = {16'd0, cfg.origin_y};
      REG_IMAGE_WIDTH:  prdata = {16'd0, cfg.image_width};
      REG_IMAGE_HEIGHT: prdata = {16'd0, cfg.image_height};
      REG_RAW_FORMAT:   prdata = {31'd0, cfg.raw_format};
      REG_TINT_ENABLE:  prdata = {31'd0, cfg.tint_enable};
      REG_TINT_COLOR:   prdata = {8'd0, cfg.tint_color};
      default:          prdata = 32'd0;
    endcase
  end

  // item intake and queue
  rab_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  // cursor skip divider
  rab_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // decoder and result register
  rab_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  // a result without a pixel carries zero coordinates and colour
  `RAB_ASSERT(a_empty_result_zero, clk, rst, pix_valid && !pix.pixel_valid |-> pix.pixel_x == 16'd0 && pix.pixel_y == 16'd0 && pix.pixel_color == 24'd0 && pix.pixel_alpha == 8'd0)
  // a finished image never asks for another word
  `RAB_ASSERT(a_done_no_want, clk, rst, pix_valid && pix.image_done |-> !pix.want_word)
  // an ignored item never produces a pixel
  `RAB_ASSERT(a_error_no_pixel, clk, rst, pix_valid && pix.status != STAT_OK |-> !pix.pixel_valid)
  // reset empties the result register and the queue
  `RAB_ASSERT_RST(a_reset_clears, clk, rst |=> !pix_valid && cmd_ready)

endmodule

/* rtl/rab_front.sv */
// front end: accepts items, decodes header fields and queues them
// depends on rab_pkg
module rab_front
  import rab_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   cmd_valid,
  output logic   cmd_ready,
  input  cmd_t   cmd,
  output logic   q_valid,
  input  logic   q_pop,
  output qitem_t q_item
);

  qitem_t     fifo_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  qitem_t     cls;
  logic [8:0] blk_len;
  logic       push;

  // classify the incoming item and pre-decode a header word
  always_comb begin
    blk_len       = BLOCK_BASE - {1'b0, cmd.data_word[7:0]};
    cls.kind      = cmd.action;
    cls.hdr_block = (cmd.data_word & HDR_BLOCK_MASK) == HDR_BLOCK_MASK;
    cls.hdr_len   = cls.hdr_block ? {7'd0, blk_len} : cmd.data_word[15:0];
    cls.word      = cmd.data_word;
  end

  assign cmd_ready = (count != 2'd2);
  assign push      = cmd_valid && cmd_ready;
  assign q_valid   = (count != 2'd0);
  assign q_item    = fifo_mem[rd_ptr];

  // two-entry queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= cls;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/rab_div.sv */
// iterative restoring divider for cursor skips, one quotient bit per cycle
// depends on rab_pkg
module rab_div
  import rab_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic [4:0]       cnt;
  logic [DIV_W-1:0] quo;
  logic [15:0]      rmd;
  logic [15:0]      dsr;
  logic [16:0]      r_sh;
  logic [16:0]      r_sub;
  logic             ge;

  // one restoring step
  always_comb begin
    r_sh  = {rmd, quo[DIV_W-1]};
    r_sub = r_sh - {1'b0, dsr};
    ge    = r_sh >= {1'b0, dsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rmd <= 16'd0;
      dsr <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], ge};
      rmd <= ge ? r_sub[15:0] : r_sh[15:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rmd;

endmodule

/* rtl/rab_back.sv */
// back end: decode state, cursor, pixel generation and the result register
// depends on rab_pkg; drives the rab_div skip divider
module rab_back
  import rab_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  qitem_t   q_item,
  output logic     q_pop,
  output div_req_t div_req,
  input  div_rsp_t div_rsp,
  output logic     pix_valid,
  input  logic     pix_ready,
  output pix_t     pix
);

  localparam logic [1:0] FS_EXEC = 2'd0;
  localparam logic [1:0] FS_SKIP = 2'd1;
  localparam logic [1:0] FS_DIV  = 2'd2;
  localparam logic [1:0] FS_FIN  = 2'd3;

  logic [1:0]  fsm, fsm_next;
  logic [31:0] total;
  logic [15:0] cursor_col, cursor_col_next;
  logic [15:0] cursor_row, cursor_row_next;
  logic [31:0] pixels_covered, pixels_covered_next;
  logic [1:0]  phase, phase_next;
  logic [15:0] block_remaining, block_remaining_next;
  logic [31:0] run_pixel, run_pixel_next;
  logic [15:0] skip_n, skip_n_next;
  pix_t        pix_next;
  logic        out_load;

  logic        out_free;
  logic        fire;
  logic        done_now;
  logic        done_next;
  logic        emit;
  logic        transparent;
  logic [31:0] rem;
  logic [31:0] emit_word;
  logic [15:0] col_inc;
  logic [15:0] hdr_clip;
  logic [15:0] run_clip;
  logic [15:0] br_dec;
  logic [16:0] skip_sum;
  logic [1:0]  stat;

  // pixel count of the whole image, registered from the width and height registers
  always_ff @(posedge clk) begin
    total <= {16'd0, cfg.image_width} * {16'd0, cfg.image_height};
  end

  // coverage and clipping
  always_comb begin
    out_free    = !pix_valid || pix_ready;
    fire        = (fsm == FS_EXEC) && q_valid && out_free;
    done_now    = pixels_covered >= total;
    rem         = done_now ? 32'd0 : total - pixels_covered;
    hdr_clip    = ({16'd0, q_item.hdr_len} < rem) ? q_item.hdr_len : rem[15:0];
    run_clip    = ({16'd0, block_remaining} > rem) ? rem[15:0] : block_remaining;
    br_dec      = (block_remaining != 16'd0) ? block_remaining - 16'd1 : 16'd0;
    transparent = cfg.tint_enable ? (q_item.word[7:0] == 8'd0)
                                  : (q_item.word[31:24] == 8'd0);
    col_inc     = cursor_col + 16'd1;
    skip_sum    = {1'b0, cursor_col} + {1'b0, skip_n};
  end

  // next state
  always_comb begin
    fsm_next             = fsm;
    cursor_col_next      = cursor_col;
    cursor_row_next      = cursor_row;
    pixels_covered_next  = pixels_covered;
    phase_next           = phase;
    block_remaining_next = block_remaining;
    run_pixel_next       = run_pixel;
    skip_n_next          = skip_n;
    emit                 = 1'b0;
    emit_word            = q_item.word;
    stat                 = STAT_OK;
    out_load             = 1'b0;
    div_req.start        = 1'b0;
    div_req.dividend     = skip_sum;
    div_req.divisor      = cfg.image_width;

    case (fsm)
      FS_EXEC: begin
        if (fire) begin
          case (q_item.kind)
            ACT_WORD: begin
              if (done_now) begin
                stat = STAT_BAD_WORD;
              end else if (cfg.raw_format) begin
                emit = 1'b1;
              end else begin
                case (phase)
                  PH_HDR: begin
                    block_remaining_next = hdr_clip;
                    if (q_item.hdr_block) begin
                      phase_next = (hdr_clip == 16'd0) ? PH_HDR : PH_BLOCK;
                    end else begin
                      phase_next = PH_RUNWORD;
                    end
                  end
                  PH_BLOCK: begin
                    emit                 = 1'b1;
                    block_remaining_next = br_dec;
                    if (br_dec == 16'd0) begin
                      phase_next = PH_HDR;
                    end
                  end
                  PH_RUNWORD: begin
                    run_pixel_next = q_item.word;
                    if (run_clip == 16'd0 || transparent) begin
                      skip_n_next          = run_clip;
                      block_remaining_next = 16'd0;
                      phase_next           = PH_HDR;
                      fsm_next             = FS_SKIP;
                    end else begin
                      block_remaining_next = run_clip;
                      phase_next           = PH_RUN;
                    end
                  end
                  default: begin
                    stat = STAT_BAD_WORD;
                  end
                endcase
              end
            end
            ACT_TICK: begin
              if (phase == PH_RUN && block_remaining != 16'd0) begin
                emit                 = 1'b1;
                emit_word            = run_pixel;
                block_remaining_next = br_dec;
                if (br_dec == 16'd0) begin
                  phase_next = PH_HDR;
                end
              end else begin
                if (phase == PH_RUN) begin
                  phase_next = PH_HDR;
                end
                stat = STAT_BAD_TICK;
              end
            end
            ACT_START: begin
              cursor_col_next      = 16'd0;
              cursor_row_next      = 16'd0;
              pixels_covered_next  = 32'd0;
              phase_next           = PH_HDR;
              block_remaining_next = 16'd0;
            end
            default: begin
            end
          endcase
          out_load = (fsm_next == FS_EXEC);
        end
      end
      FS_SKIP: begin
        pixels_covered_next = pixels_covered + {16'd0, skip_n};
        if (cfg.image_width == 16'd0) begin
          fsm_next = FS_FIN;
        end else if (skip_sum < {1'b0, cfg.image_width}) begin
          cursor_col_next = skip_sum[15:0];
          fsm_next        = FS_FIN;
        end else begin
          div_req.start = 1'b1;
          fsm_next      = FS_DIV;
        end
      end
      FS_DIV: begin
        if (div_rsp.done) begin
          cursor_row_next = cursor_row + div_rsp.quotient[15:0];
          cursor_col_next = div_rsp.remainder;
          fsm_next        = FS_FIN;
        end
      end
      FS_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          fsm_next = FS_EXEC;
        end
      end
      default: begin
        fsm_next = FS_EXEC;
      end
    endcase

    // cursor advance for an emitted pixel
    if (emit) begin
      pixels_covered_next = pixels_covered + 32'd1;
      if (col_inc >= cfg.image_width) begin
        cursor_col_next = 16'd0;
        cursor_row_next = cursor_row + 16'd1;
      end else begin
        cursor_col_next = col_inc;
      end
    end

    // result assembly
    done_next            = pixels_covered_next >= total;
    pix_next.pixel_valid = emit;
    pix_next.pixel_x     = emit ? cfg.origin_x + cursor_col : 16'd0;
    pix_next.pixel_y     = emit ? cfg.origin_y + cursor_row : 16'd0;
    pix_next.pixel_color = !emit           ? 24'd0 :
                           cfg.tint_enable ? cfg.tint_color : emit_word[23:0];
    pix_next.pixel_alpha = !emit           ? 8'd0 :
                           cfg.tint_enable ? emit_word[7:0] : emit_word[31:24];
    pix_next.want_word   = !done_next && (cfg.raw_format || phase_next != PH_RUN);
    pix_next.image_done  = done_next;
    pix_next.status      = stat;
  end

  assign q_pop = fire;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm             <= FS_EXEC;
      cursor_col      <= 16'd0;
      cursor_row      <= 16'd0;
      pixels_covered  <= 32'd0;
      phase           <= PH_HDR;
      block_remaining <= 16'd0;
      run_pixel       <= 32'd0;
      pix_valid       <= 1'b0;
    end else begin
      fsm             <= fsm_next;
      cursor_col      <= cursor_col_next;
      cursor_row      <= cursor_row_next;
      pixels_covered  <= pixels_covered_next;
      phase           <= phase_next;
      block_remaining <= block_remaining_next;
      run_pixel       <= run_pixel_next;
      if (out_load) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    skip_n <= skip_n_next;
    if (out_load) begin
      pix <= pix_next;
    end
  end

endmodule
